/* design/overwriting_ring_buffer_with_average_unit_defines.svh */
`ifndef OVERWRITING_RING_BUFFER_WITH_AVERAGE_UNIT_DEFINES_SVH
`define OVERWRITING_RING_BUFFER_WITH_AVERAGE_UNIT_DEFINES_SVH

// same-cycle implication
`define ORBAVG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("orbavg check failed");

// next-cycle implication
`define ORBAVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("orbavg check failed");

`endif

/* design/orbavg_pkg.sv */
package orbavg_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int DATA_W = 32;
   localparam int SUM_W  = DATA_W + ADDR_W;
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int CMD_W  = 2;
   localparam int CSR_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_GET   = 2'd1,
      CMD_CLEAR = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_COUNT,
      ST_DIV,
      ST_LOAD
   } state_type;

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p,
                                                  input logic [CNT_W-1:0]  cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(p) + CNT_W'(1);
      return (n >= cap) ? '0 : n[ADDR_W-1:0];
   endfunction

endpackage

/* design/orbavg_if.sv */
interface orbavg_req_if import orbavg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output command, output write_data, input ready);
   modport sink   (input valid, input command, input write_data, output ready);
endinterface

interface orbavg_rsp_if import orbavg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              read_ok;
   logic              full_flag;
   logic              empty_flag;
   logic [CNT_W-1:0]  entry_count;
   logic [DATA_W-1:0] average;

   modport source (output valid, output read_data, output read_ok, output full_flag,
                   output empty_flag, output entry_count, output average, input ready);
   modport sink   (input valid, input read_data, input read_ok, input full_flag,
                   input empty_flag, input entry_count, input average, output ready);
endinterface

/* design/orbavg_div.sv */
module orbavg_div import orbavg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff,  rem_in;
   logic [CNT_W-1:0]  div_ff,  div_in;
   logic [SUM_W-1:0]  quo_ff,  quo_in;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    rem_next;
   logic              fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      fits     = (trial >= {1'b0, div_ff});
      rem_next = fits ? (trial - {1'b0, div_ff}) : trial;

      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;

      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(SUM_W);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (run_ff) begin
         // shift one quotient bit in per cycle
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = rem_next[CNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/overwriting_ring_buffer_with_average_unit.sv */
// Each item passes the read, update and count states, then the bit-serial
// 38-step divider for the average, then the load state; a new item is only
// accepted in the idle state, after the last one has been loaded.
// The output register lets the next item enter while a result waits.
// Reset (synchronous, active high): ring empty, sum zero, capacity 64;
// the sample store keeps its contents and is never cleared.
module overwriting_ring_buffer_with_average_unit import orbavg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CSR_W-1:0] csr_write_data,
   orbavg_req_if.sink       req_chan,
   orbavg_rsp_if.source     rsp_chan
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic              full_ff, full_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic              ok_ff, ok_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_rd_ff;
   logic              rsp_ok_ff;
   logic              rsp_full_ff;
   logic              rsp_empty_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;
   logic [DATA_W-1:0] rsp_avg_ff, rsp_avg_in;

   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [DATA_W-1:0] mem_rdata_ff;
   logic [ADDR_W-1:0] mem_raddr;
   logic              mem_we;

   logic [ADDR_W-1:0] wp_next;
   logic [ADDR_W-1:0] rp_next;
   logic [CNT_W-1:0]  held;
   logic [CNT_W-1:0]  cap_sat;
   logic              rsp_load;
   logic              div_start;
   logic              div_done;
   logic [SUM_W-1:0]  div_quotient;

   orbavg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (held),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign mem_raddr = (cmd_ff == CMD_PUT) ? wp_ff : rp_ff;
   assign mem_we    = (state_ff == ST_CALC) && (cmd_ff == CMD_PUT);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wp_ff] <= data_ff;
      end
      mem_rdata_ff <= store_mem[mem_raddr];
   end

   always_comb begin
      if (full_ff) begin
         held = cap_ff;
      end else if (wp_ff >= rp_ff) begin
         held = CNT_W'(wp_ff) - CNT_W'(rp_ff);
      end else begin
         held = cap_ff + CNT_W'(wp_ff) - CNT_W'(rp_ff);
      end

      if (csr_write_data == '0) begin
         cap_sat = CNT_W'(1);
      end else if (int'(csr_write_data) > DEPTH) begin
         cap_sat = CNT_W'(DEPTH);
      end else begin
         cap_sat = CNT_W'(csr_write_data);
      end
   end

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      full_in   = full_ff;
      sum_in    = sum_ff;
      cap_in    = cap_ff;
      cmd_in    = cmd_ff;
      data_in   = data_ff;
      rd_in     = rd_ff;
      ok_in     = ok_ff;
      cnt_in    = cnt_ff;
      wp_next   = next_slot(wp_ff, cap_ff);
      rp_next   = next_slot(rp_ff, cap_ff);
      div_start = 1'b0;
      rsp_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.command;
               data_in  = req_chan.write_data;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            rd_in = '0;
            ok_in = 1'b0;
            case (cmd_ff)
               CMD_PUT: begin
                  // drop the overwritten oldest word from the sum
                  sum_in = sum_ff - (full_ff ? SUM_W'(mem_rdata_ff) : '0)
                           + SUM_W'(data_ff);
                  wp_in   = wp_next;
                  rp_in   = full_ff ? rp_next : rp_ff;
                  full_in = (wp_next == (full_ff ? rp_next : rp_ff));
               end
               CMD_GET: begin
                  if (full_ff || (wp_ff != rp_ff)) begin
                     rd_in   = mem_rdata_ff;
                     ok_in   = 1'b1;
                     sum_in  = sum_ff - SUM_W'(mem_rdata_ff);
                     full_in = 1'b0;
                     rp_in   = rp_next;
                  end
               end
               CMD_CLEAR: begin
                  wp_in   = '0;
                  rp_in   = '0;
                  full_in = 1'b0;
                  sum_in  = '0;
               end
               default: begin
               end
            endcase
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cnt_in   = held;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff == ST_COUNT) begin
         div_start = 1'b1;
      end

      if (csr_write_enable) begin
         cap_in  = cap_sat;
         wp_in   = '0;
         rp_in   = '0;
         full_in = 1'b0;
         sum_in  = '0;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_avg_in = (cnt_ff == '0) ? '0 : div_quotient[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      data_ff <= data_in;
      rd_ff   <= rd_in;
      ok_ff   <= ok_in;
      cnt_ff  <= cnt_in;
      if (rsp_load) begin
         rsp_rd_ff    <= rd_ff;
         rsp_ok_ff    <= ok_ff;
         rsp_full_ff  <= full_ff;
         rsp_empty_ff <= (cnt_ff == '0);
         rsp_cnt_ff   <= cnt_ff;
         rsp_avg_ff   <= rsp_avg_in;
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_data   = rsp_rd_ff;
   assign rsp_chan.read_ok     = rsp_ok_ff;
   assign rsp_chan.full_flag   = rsp_full_ff;
   assign rsp_chan.empty_flag  = rsp_empty_ff;
   assign rsp_chan.entry_count = rsp_cnt_ff;
   assign rsp_chan.average     = rsp_avg_ff;

endmodule

/* design/orbavg_chk.sv */
`include "overwriting_ring_buffer_with_average_unit_defines.svh"

module orbavg_chk import orbavg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_read_data,
   input logic              rsp_read_ok,
   input logic              rsp_full_flag,
   input logic              rsp_empty_flag,
   input logic [CNT_W-1:0]  rsp_entry_count,
   input logic [DATA_W-1:0] rsp_average
);

   // hold a stalled item
   `ORBAVG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_average) && $stable(rsp_entry_count))

   `ORBAVG_ASSERT_IMPL(a_empty_count, clock, reset, rsp_valid, rsp_empty_flag == (rsp_entry_count == '0))

   `ORBAVG_ASSERT_IMPL(a_full_not_empty, clock, reset, rsp_valid && rsp_full_flag, !rsp_empty_flag)

   `ORBAVG_ASSERT_IMPL(a_no_word_zero, clock, reset, rsp_valid && !rsp_read_ok, rsp_read_data == '0)

   `ORBAVG_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, (rsp_entry_count <= CNT_W'(DEPTH)) && ((rsp_entry_count != '0) || (rsp_average == '0)))

endmodule

bind overwriting_ring_buffer_with_average_unit orbavg_chk u_orbavg_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_read_data   (rsp_chan.read_data),
   .rsp_read_ok     (rsp_chan.read_ok),
   .rsp_full_flag   (rsp_chan.full_flag),
   .rsp_empty_flag  (rsp_chan.empty_flag),
   .rsp_entry_count (rsp_chan.entry_count),
   .rsp_average     (rsp_chan.average)
);
